>>> src/wepenc_pkg.sv
`timescale 1ns / 1ps

package wepenc_pkg;

    typedef logic [7:0] t_byte;

    localparam int          IV_BYTES  = 3;
    localparam int          IV_W      = 24;
    localparam int          KEY_W     = 40;
    localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;

    // reflected crc-32, one data byte folded in
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input t_byte b);
        logic [31:0] c;
        c = crc ^ {24'h0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

>>> src/wep_rc4_frame_encrypt_core.sv
`timescale 1ns / 1ps

// channel   | direction | tdata / data (lsb first)            | tuser          | tlast
// ----------+-----------+-------------------------------------+----------------+-----------
// cfg       | in        | i_cfg_data = wep_key[39:0]          | -              | -
// s_axis    | in        | init_vector[23:0], data_byte[31:24] | first_byte     | last_byte
// m_axis    | out       | cipher_byte[7:0]                    | is_icv         | frame_end
//
// a plain byte passes one accept step, four sbox memory steps for the
// rc4 generator (read i, read j, write i, write j with read of the output entry)
// and one step that loads the output word.
// a frame's first byte adds an sbox fill and a key schedule over all 256 entries.
// a last byte adds a generator pass for each of the four encrypted icv bytes.
// reset is synchronous, active low; the sbox itself is not cleared.
// a stalled output word holds the generator in its last step; input is taken only
// between bytes, while a finished word may still wait on m_axis.
module wep_rc4_frame_encrypt_core
    import wepenc_pkg::*;
#(
    parameter int KEY_BYTES = 5
) (
    input  logic             i_clk,
    input  logic             i_rst_n,

    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [KEY_W-1:0] i_cfg_data,     // wep_key

    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [31:0]      s_axis_tdata,   // init_vector[23:0], data_byte[31:24]
    input  logic             s_axis_tlast,   // last_byte
    input  logic [0:0]       s_axis_tuser,   // first_byte

    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // cipher_byte[7:0]
    output logic             m_axis_tlast,   // frame_end
    output logic [0:0]       m_axis_tuser    // is_icv
);

    localparam int SEED_BYTES = IV_BYTES + KEY_BYTES;
    localparam int SCW        = $clog2(SEED_BYTES);
    localparam logic [SCW:0]   SEED_LAST = (SCW+1)'(SEED_BYTES - 1);
    localparam logic [SCW-1:0] SEED_WRAP = SCW'(SEED_BYTES - 1);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_INIT = 4'd1;
    localparam logic [3:0] ST_KA   = 4'd2;
    localparam logic [3:0] ST_KB   = 4'd3;
    localparam logic [3:0] ST_KC   = 4'd4;
    localparam logic [3:0] ST_KD   = 4'd5;
    localparam logic [3:0] ST_G0   = 4'd6;
    localparam logic [3:0] ST_G1   = 4'd7;
    localparam logic [3:0] ST_G2   = 4'd8;
    localparam logic [3:0] ST_G3   = 4'd9;
    localparam logic [3:0] ST_G4   = 4'd10;

    localparam logic [2:0] PH_DATA = 3'd0;
    localparam logic [2:0] PH_LAST = 3'd4;

    t_byte r_sbox [256];
    t_byte r_rd;

    logic [3:0]       r_state, n_state;
    logic [KEY_W-1:0] r_key;
    logic [IV_W-1:0]  r_iv;
    t_byte            r_data;
    logic             r_last;
    t_byte            r_i, n_i;
    t_byte            r_j, n_j;
    t_byte            r_si, n_si;
    t_byte            r_sj, n_sj;
    logic             r_fwd, n_fwd;
    logic [SCW-1:0]   r_seed_idx, n_seed_idx;
    logic [31:0]      r_crc;
    logic [31:0]      r_icv;
    logic [2:0]       r_phase;
    logic             r_out_valid;
    t_byte            r_out_data;
    logic             r_out_icv;
    logic             r_out_end;

    logic        w_in_acc;
    logic        w_out_free;
    logic        mem_we, mem_re;
    t_byte       mem_wa, mem_wd, mem_ra;
    t_byte       w_t, w_ks, w_seed;
    logic [SCW:0]       w_kb;
    logic [KEY_W-1:0]   w_key_sh;
    logic [31:0]        w_crc_next;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc      = s_axis_tvalid & s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out_data;
    assign m_axis_tlast    = r_out_end;
    assign m_axis_tuser[0] = r_out_icv;

    // seed byte: iv bytes first, then key bytes, first key byte from the top
    assign w_kb     = SEED_LAST - {1'b0, r_seed_idx};
    assign w_key_sh = r_key >> {w_kb, 3'b000};
    always_comb begin
        case (r_seed_idx)
            SCW'(0): w_seed = r_iv[23:16];
            SCW'(1): w_seed = r_iv[15:8];
            SCW'(2): w_seed = r_iv[7:0];
            default: w_seed = w_key_sh[7:0];
        endcase
    end

    assign w_t        = r_si + r_sj;
    assign w_ks       = r_fwd ? r_si : r_rd;
    assign w_crc_next = crc32_byte(s_axis_tuser[0] ? CRC_INIT : r_crc, s_axis_tdata[31:24]);

    always_comb begin
        n_state    = r_state;
        n_i        = r_i;
        n_j        = r_j;
        n_si       = r_si;
        n_sj       = r_sj;
        n_fwd      = r_fwd;
        n_seed_idx = r_seed_idx;
        mem_we     = 1'b0;
        mem_wa     = r_i;
        mem_wd     = r_si;
        mem_re     = 1'b0;
        mem_ra     = r_i;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (s_axis_tuser[0]) begin
                        n_state    = ST_INIT;
                        n_i        = 8'd0;
                        n_j        = 8'd0;
                        n_seed_idx = '0;
                    end else begin
                        n_state = ST_G0;
                    end
                end
            end
            ST_INIT: begin
                mem_we = 1'b1;
                mem_wa = r_i;
                mem_wd = r_i;
                n_i    = r_i + 8'd1;
                if (r_i == 8'hFF) n_state = ST_KA;
            end
            ST_KA: begin
                mem_re  = 1'b1;
                mem_ra  = r_i;
                n_state = ST_KB;
            end
            ST_KB: begin
                n_si    = r_rd;
                n_j     = r_j + r_rd + w_seed;
                mem_re  = 1'b1;
                mem_ra  = n_j;
                n_state = ST_KC;
            end
            ST_KC: begin
                mem_we  = 1'b1;
                mem_wa  = r_i;
                mem_wd  = r_rd;
                n_state = ST_KD;
            end
            ST_KD: begin
                mem_we     = 1'b1;
                mem_wa     = r_j;
                mem_wd     = r_si;
                n_i        = r_i + 8'd1;
                n_seed_idx = (r_seed_idx == SEED_WRAP) ? '0 : r_seed_idx + SCW'(1);
                if (r_i == 8'hFF) begin
                    n_j     = 8'd0;
                    n_state = ST_G0;
                end else begin
                    n_state = ST_KA;
                end
            end
            ST_G0: begin
                n_i     = r_i + 8'd1;
                mem_re  = 1'b1;
                mem_ra  = n_i;
                n_state = ST_G1;
            end
            ST_G1: begin
                n_si    = r_rd;
                n_j     = r_j + r_rd;
                mem_re  = 1'b1;
                mem_ra  = n_j;
                n_state = ST_G2;
            end
            ST_G2: begin
                n_sj    = r_rd;
                mem_we  = 1'b1;
                mem_wa  = r_i;
                mem_wd  = r_rd;
                n_state = ST_G3;
            end
            ST_G3: begin
                // the write to entry j lands this cycle, so a read of j is forwarded
                mem_we  = 1'b1;
                mem_wa  = r_j;
                mem_wd  = r_si;
                mem_re  = 1'b1;
                mem_ra  = w_t;
                n_fwd   = (w_t == r_j);
                n_state = ST_G4;
            end
            ST_G4: begin
                if (w_out_free) begin
                    if ((r_phase == PH_DATA && !r_last) || r_phase == PH_LAST) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_G0;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // sbox memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) r_sbox[mem_wa] <= mem_wd;
        if (mem_re) r_rd <= r_sbox[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        r_si       <= n_si;
        r_sj       <= n_sj;
        r_fwd      <= n_fwd;
        r_seed_idx <= n_seed_idx;
        if (w_in_acc) begin
            r_data <= s_axis_tdata[31:24];
            r_last <= s_axis_tlast;
            if (s_axis_tuser[0]) r_iv <= s_axis_tdata[23:0];
            if (s_axis_tlast) r_icv <= ~w_crc_next;
        end
        if (r_state == ST_G4 && w_out_free) begin
            r_out_data <= ((r_phase == PH_DATA) ? r_data : r_icv[7:0]) ^ w_ks;
            r_out_icv  <= (r_phase != PH_DATA);
            r_out_end  <= (r_phase == PH_LAST);
            if (r_phase != PH_DATA) r_icv <= r_icv >> 8;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_key       <= '0;
            r_i         <= 8'd0;
            r_j         <= 8'd0;
            r_crc       <= CRC_INIT;
            r_phase     <= PH_DATA;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            if (i_cfg_valid && o_cfg_ready) r_key <= i_cfg_data;
            if (w_in_acc) begin
                r_phase <= PH_DATA;
                r_crc   <= s_axis_tlast ? CRC_INIT : w_crc_next;
            end else if (r_state == ST_G4 && w_out_free && r_phase != PH_LAST) begin
                r_phase <= r_phase + 3'd1;
            end
            if (r_state == ST_G4 && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_end_is_icv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_end) |-> r_out_icv)
        else $error("frame end word not marked as icv");

    a_first_starts_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && s_axis_tuser[0]) |=> (r_state == ST_INIT && r_i == 8'd0))
        else $error("frame start did not begin sbox fill");

    a_plain_starts_gen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && !s_axis_tuser[0]) |=> (r_state == ST_G0))
        else $error("plain word did not start generator");

    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !mem_we)
        else $error("sbox written while idle");

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase <= PH_LAST))
        else $error("icv phase out of range");

    a_ksa_exit_clears_j: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_KD && r_i == 8'hFF) |=> (r_state == ST_G0 && r_j == 8'd0 && r_i == 8'd0))
        else $error("key schedule left generator indices nonzero");

endmodule

>>> test/wep_rc4_frame_encrypt_core_tb.sv
`timescale 1ns / 1ps

module wep_rc4_frame_encrypt_core_tb;
    import wepenc_pkg::*;

    localparam int KEY_BYTES      = 5;
    localparam int SEED_BYTES     = IV_BYTES + KEY_BYTES;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 3000;

    typedef struct packed {
        logic [7:0] cipher;
        logic       icv;
        logic       fend;
    } t_cipher_word;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [KEY_W-1:0] i_cfg_data;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [31:0]      s_axis_tdata;
    logic             s_axis_tlast;
    logic [0:0]       s_axis_tuser;
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [7:0]       m_axis_tdata;
    logic             m_axis_tlast;
    logic [0:0]       m_axis_tuser;

    // encryptor state as the testbench sees it
    logic [KEY_W-1:0] key_m;
    logic [7:0]       sbox_m [256];
    logic [7:0]       gen_i;
    logic [7:0]       gen_j;
    logic [31:0]      crc_m;
    t_cipher_word     cipher_q [$];

    int idle_pct;
    int stall_pct;
    int hold_left;
    int quiet_cycles;
    int n_errors;
    int n_sent;
    int n_recv;
    int n_frames;
    int n_keys;

    wep_rc4_frame_encrypt_core #(
        .KEY_BYTES(KEY_BYTES)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .m_axis_tuser (m_axis_tuser)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic logic [7:0] seed_byte(input logic [IV_W-1:0] iv, input int n);
        int sh;
        if (n < IV_BYTES) begin
            return iv[8*(IV_BYTES-1-n) +: 8];
        end
        sh = 8 * (KEY_BYTES - 1 - (n - IV_BYTES));
        // key bytes beyond the 40-bit register read as zero
        if (sh >= KEY_W) begin
            return 8'h00;
        end
        return 8'(key_m >> sh);
    endfunction

    function automatic void rc4_schedule(input logic [IV_W-1:0] iv);
        logic [7:0] j;
        logic [7:0] t;
        j = 8'h00;
        for (int n = 0; n < 256; n++) begin
            sbox_m[n] = n[7:0];
        end
        for (int n = 0; n < 256; n++) begin
            j = j + sbox_m[n] + seed_byte(iv, n % SEED_BYTES);
            t = sbox_m[n];
            sbox_m[n] = sbox_m[j];
            sbox_m[j] = t;
        end
        gen_i = 8'h00;
        gen_j = 8'h00;
    endfunction

    function automatic logic [7:0] rc4_keystream();
        logic [7:0] t;
        logic [7:0] sum;
        gen_i = gen_i + 8'd1;
        gen_j = gen_j + sbox_m[gen_i];
        t = sbox_m[gen_i];
        sbox_m[gen_i] = sbox_m[gen_j];
        sbox_m[gen_j] = t;
        sum = sbox_m[gen_i] + sbox_m[gen_j];
        return sbox_m[sum];
    endfunction

    function automatic void predict_cipher(input logic [IV_W-1:0] iv, input logic [7:0] data,
                                           input logic first, input logic last);
        t_cipher_word w;
        logic [31:0]  icv;
        if (first) begin
            rc4_schedule(iv);
            crc_m = CRC_INIT;
        end
        w.cipher = data ^ rc4_keystream();
        w.icv    = 1'b0;
        w.fend   = 1'b0;
        cipher_q.push_back(w);
        crc_m = crc_m ^ {24'h0, data};
        for (int k = 0; k < 8; k++) begin
            crc_m = crc_m[0] ? ((crc_m >> 1) ^ CRC_POLY) : (crc_m >> 1);
        end
        if (last) begin
            icv = ~crc_m;
            for (int k = 0; k < 4; k++) begin
                w.cipher = icv[8*k +: 8] ^ rc4_keystream();
                w.icv    = 1'b1;
                w.fend   = (k == 3);
                cipher_q.push_back(w);
            end
            crc_m = CRC_INIT;
        end
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_byte(input logic [IV_W-1:0] iv, input logic [7:0] data,
                             input logic first, input logic last);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {data, iv};
        s_axis_tuser  <= first;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_cipher(iv, data, first, last);
        n_sent++;
        if (first) begin
            n_frames++;
        end
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (cipher_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (10) @(negedge i_clk);
    endtask

    task automatic load_key(input logic [KEY_W-1:0] key);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= key;
        do @(posedge i_clk); while (!o_cfg_ready);
        key_m = key;
        n_keys++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_directed();
        idle_pct  = 0;
        stall_pct = 0;
        load_key('0);
        // one-byte frame with all-zero seed
        send_byte(24'h000000, 8'h00, 1'b1, 1'b1);
        load_key('1);
        send_byte(24'hFFFFFF, 8'hFF, 1'b1, 1'b0);
        send_byte(IV_W'($urandom), 8'h00, 1'b0, 1'b0);
        send_byte(IV_W'($urandom), 8'h80, 1'b0, 1'b0);
        send_byte(IV_W'($urandom), 8'h01, 1'b0, 1'b1);
        // bytes after the icv with no frame start keep the generator running
        send_byte(IV_W'($urandom), 8'h5A, 1'b0, 1'b0);
        send_byte(IV_W'($urandom), 8'hA5, 1'b0, 1'b1);
        // frame dropped without a last byte, then restarted
        send_byte(24'h123456, 8'h00, 1'b1, 1'b0);
        send_byte(24'hABCDEF, 8'hFF, 1'b1, 1'b0);
        send_byte(IV_W'($urandom), 8'h7F, 1'b0, 1'b0);
        send_byte(IV_W'($urandom), 8'hFE, 1'b0, 1'b0);
        send_byte(IV_W'($urandom), 8'h55, 1'b0, 1'b1);
        load_key(40'hA5_5A_A5_5A_A5);
        send_byte(24'h800001, 8'h3C, 1'b1, 1'b1);
        send_byte(24'h7FFFFE, 8'hC3, 1'b1, 1'b1);
    endtask

    task automatic test_random_frames(input int n_items, input int idle, input int stall);
        int sent;
        int len;
        logic [IV_W-1:0] iv;
        load_key(KEY_W'({$urandom, $urandom}));
        idle_pct  = idle;
        stall_pct = stall;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(9) == 0) begin
                // stray byte outside a well-formed frame
                send_byte(IV_W'($urandom), 8'($urandom), 1'b0, 1'($urandom_range(1)));
                sent++;
            end else begin
                len = ($urandom_range(7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
                iv  = IV_W'($urandom);
                for (int k = 0; k < len; k++) begin
                    send_byte((k == 0) ? iv : IV_W'($urandom), 8'($urandom), k == 0,
                              (k == len - 1) && ($urandom_range(15) != 0));
                end
                sent += len;
            end
        end
    endtask

    task automatic test_backpressure();
        load_key(KEY_W'({$urandom, $urandom}));
        idle_pct  = 0;
        stall_pct = 0;
        hold_left = HOLD_CYCLES;
        for (int k = 0; k < 16; k++) begin
            send_byte(IV_W'($urandom), 8'($urandom), k == 0, k == 15);
        end
    endtask

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin : check_cipher
        t_cipher_word want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_recv++;
            if (cipher_q.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected word cipher=%02h icv=%0b end=%0b", $time,
                         m_axis_tdata, m_axis_tuser, m_axis_tlast);
            end else begin
                want = cipher_q.pop_front();
                if (m_axis_tdata !== want.cipher || m_axis_tuser !== want.icv ||
                    m_axis_tlast !== want.fend) begin
                    n_errors++;
                    $display("%0t: mismatch expected cipher=%02h icv=%0b end=%0b",
                             $time, want.cipher, want.icv, want.fend);
                    $display("%0t: mismatch actual   cipher=%02h icv=%0b end=%0b",
                             $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no word accepted for %0d cycles", $time, quiet_cycles);
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b0;
        key_m         = '0;
        gen_i         = 8'h00;
        gen_j         = 8'h00;
        crc_m         = CRC_INIT;
        idle_pct      = 0;
        stall_pct     = 0;
        hold_left     = 0;
        quiet_cycles  = 0;
        n_errors      = 0;
        n_sent        = 0;
        n_recv        = 0;
        n_frames      = 0;
        n_keys        = 0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_directed();
        test_random_frames(80, 0, 0);
        test_random_frames(80, 67, 0);
        test_random_frames(80, 0, 67);
        test_random_frames(80, 8, 8);
        test_backpressure();

        wait_idle();
        repeat (50) @(posedge i_clk);
        $display("encrypted %0d bytes in %0d frames under %0d keys, %0d words checked",
                 n_sent, n_frames, n_keys, n_recv);
        $display("covered one-byte and dropped frames, stray bytes, icv output and long stalls");
        if (n_errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
